>>> rtl/fdrf_pkg.sv
// Package for the flooding duplicate filter: item payload types, the cache
// entry layout, register codes and reset values. No dependencies.
package fdrf_pkg;

   // Saturation limit and width of a seen count.
   localparam int COUNT_MAX = 255;
   localparam int COUNT_W   = 8;

   // Configuration register map, one 32-bit word per register.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_COPIES_THRESHOLD = 1'b0;
   localparam logic REG_PAUSE_MS         = 1'b1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd20;
   localparam logic [31:0] PAUSE_RESET     = 32'd1000;

   // Mode codes of an input item.
   localparam logic MODE_RECEIVED = 1'b0;
   localparam logic MODE_SENT     = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] pkt_id;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic is_new;
      logic transmit;
      logic paused;
   } rsp_payload_type;

   // One slot of the recent id ring.
   typedef struct packed {
      logic [15:0]        pkt_id;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

>>> rtl/flood_dedup_rebroadcast_filter_core.sv
// Top level of the flooding duplicate filter with congestion pause.
// Depends on fdrf_pkg and fdrf_ram.
//
//   Channel   Ports                               Direction  Moves
//   req       req_valid, req_stall, req_payload   in         one packet item
//   rsp       rsp_valid, rsp_stall, rsp_payload   out        one verdict item
//   csr       psel, penable, pwrite, paddr, ...   in/out     threshold, pause
//
// The cache ring sits in one RAM with a registered read port, so each slot costs
// a read state and a check state, followed by an update state and an output
// state.
// A received id that hits a slot ends the scan early.
// Reset clears the control state, the slot valid bits, the oldest pointer and
// the resume time; a slot never written reads as id zero with count zero.
// A new item is taken while an earlier verdict still waits on a stalled rsp
// channel; the verdict of the new item waits in the output cycle until the
// output register is free.
module flood_dedup_rebroadcast_filter_core
   import fdrf_pkg::*;
#(
   parameter int CACHE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_W = $clog2(CACHE_DEPTH);
   localparam int SUM_W = $clog2(CACHE_DEPTH * COUNT_MAX + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(COUNT_MAX);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_CHECK  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_OUT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] threshold_ff, threshold_in;
   logic [31:0] pause_ff, pause_in;

   // Item being worked on.
   logic        mode_ff, mode_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] now_ff, now_in;

   // Scan state.
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               hit_ff, hit_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               paused_ff, paused_in;

   // Persistent filter state.
   logic [CACHE_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       oldest_ff, oldest_in;
   logic [31:0]            resume_ff, resume_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // RAM ports.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   entry_type        ram_rd_data;
   entry_type        entry;

   logic req_accept;
   logic csr_write;
   logic out_free;
   logic slot_match;

   fdrf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CACHE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // A slot that has never been written holds id zero with a zero count.
   assign entry = valid_ff[idx_ff] ? ram_rd_data : '0;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_match = (mode_ff == MODE_RECEIVED) && (entry.pkt_id == id_ff);

   // Configuration port: every write completes in its access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   always_comb begin
      case (paddr[2])
         REG_COPIES_THRESHOLD: prdata = {16'd0, threshold_ff};
         REG_PAUSE_MS:         prdata = pause_ff;
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      threshold_in = threshold_ff;
      pause_in     = pause_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_COPIES_THRESHOLD: threshold_in = pwdata[15:0];
            REG_PAUSE_MS:         pause_in     = pwdata;
            default:              ;
         endcase
      end
   end

   // Sequencer. An adder accumulates the seen counts during the scan.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      hit_in         = hit_ff;
      cnt_in         = cnt_ff;
      paused_in      = paused_ff;
      valid_in       = valid_ff;
      oldest_in      = oldest_ff;
      resume_in      = resume_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = oldest_ff;
      ram_wr_data    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in  = req_payload.mode;
               id_in    = req_payload.pkt_id;
               now_in   = req_payload.now_ms;
               idx_in   = '0;
               sum_in   = '0;
               hit_in   = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            sum_in = sum_ff + SUM_W'(entry.count);
            cnt_in = entry.count;
            if (slot_match) begin
               // Lowest matching slot wins; idx stays on it for the update.
               hit_in   = 1'b1;
               state_in = S_UPDATE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_UPDATE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_UPDATE: begin
            ram_wr_en = 1'b1;
            if (hit_ff) begin
               ram_wr_addr        = idx_ff;
               ram_wr_data.pkt_id = id_ff;
               ram_wr_data.count  = (cnt_ff == COUNT_SAT) ? cnt_ff : cnt_ff + 1'b1;
               valid_in[idx_ff]   = 1'b1;
               paused_in          = 1'b0;
            end else begin
               // Insert over the oldest slot; the pause decision uses the sum
               // of counts taken before the overwrite.
               paused_in = (16'(sum_ff) > threshold_ff);
               if (paused_in) begin
                  resume_in = now_ff + pause_ff;
               end
               ram_wr_addr         = oldest_ff;
               ram_wr_data.pkt_id  = id_ff;
               ram_wr_data.count   = '0;
               valid_in[oldest_ff] = 1'b1;
               oldest_in = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in.is_new   = (mode_ff == MODE_RECEIVED) && !hit_ff;
               rsp_payload_in.transmit = (mode_ff == MODE_SENT) ||
                  (!hit_ff && ((resume_ff == '0) || (resume_ff < now_ff)));
               rsp_payload_in.paused   = paused_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         pause_ff     <= PAUSE_RESET;
         valid_ff     <= '0;
         oldest_ff    <= '0;
         resume_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         paused_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         pause_ff     <= pause_in;
         valid_ff     <= valid_in;
         oldest_ff    <= oldest_in;
         resume_ff    <= resume_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         paused_ff    <= paused_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      now_ff         <= now_in;
      idx_ff         <= idx_in;
      sum_ff         <= sum_in;
      cnt_ff         <= cnt_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // An accepted item always starts its scan at the lowest slot.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_READ) && (idx_ff == '0))
      else $error("scan did not start at slot zero");

   // A hit only bumps a count; the oldest pointer and resume time stay put.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) && hit_ff |=> $stable(oldest_ff) && $stable(resume_ff))
      else $error("hit disturbed the ring order or the resume time");

   // The output cycle hands its verdict over as soon as the register frees.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("verdict not delivered from the output cycle");

   // An old received packet is neither transmitted nor able to start a pause.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.is_new && !rsp_payload_ff.transmit
         |-> !rsp_payload_ff.paused)
      else $error("duplicate verdict reports a pause");

endmodule

>>> rtl/fdrf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fdrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
